@@ src/vocd_pkg.sv @@
// Shared types and constants for the video object collision detector.
// No dependencies.
package vocd_pkg;

  localparam int SPRITE_NUM = 4;
  localparam int CHAR_COUNT = 16;
  localparam int VSEG_COUNT = 128;
  localparam int HSEG_COUNT = 128;
  localparam int SEG_DEPTH  = (VSEG_COUNT > HSEG_COUNT) ? VSEG_COUNT : HSEG_COUNT;
  localparam int SEG_AW     = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
  localparam int CHAR_AW    = (CHAR_COUNT > 1) ? $clog2(CHAR_COUNT) : 1;

  localparam logic [7:0] HIDDEN_Y = 8'd248;
  localparam logic [8:0] VSEG_DY  = 9'd23;
  localparam logic [8:0] HSEG_DX  = 9'd15;
  localparam logic [8:0] HSEG_DY  = 9'd2;
  localparam logic [8:0] DOT_SDX  = 9'd3;
  localparam logic [8:0] DOT_CDX  = 9'd15;
  localparam logic [8:0] CHAR_DX  = 9'd7;

  typedef enum logic [2:0] {
    ACT_SPRITE = 3'd0,
    ACT_CHAR   = 3'd1,
    ACT_VSEG   = 3'd2,
    ACT_HSEG   = 3'd3,
    ACT_DOT    = 3'd4,
    ACT_QUERY  = 3'd5
  } action_t;

  // One segment-memory word: vertical segment, horizontal segment, dot.
  typedef struct packed {
    logic       v_on;
    logic [7:0] v_x0;
    logic [7:0] v_x1;
    logic [7:0] v_y0;
    logic       h_on;
    logic [7:0] h_x0;
    logic [7:0] h_y0;
    logic [7:0] d_x0;
    logic [7:0] d_y0;
  } seg_word_t;

  localparam int SEG_W = $bits(seg_word_t);

  function automatic logic ends_hit(input logic [8:0] as, input logic [8:0] ae,
                                    input logic [8:0] lo, input logic [8:0] hi);
    ends_hit = ((as >= lo) && (as <= hi)) || ((ae >= lo) && (ae <= hi));
  endfunction

endpackage

@@ src/vocd_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module vocd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ src/video_object_collision_detector.sv @@
// Top level of the video object collision detector.
// Depends on vocd_pkg and vocd_ram.
//
// Sprite and character write beats update their register tables at the
// accepting edge, so the next beat can be taken in the cycle after. Segment
// and dot entries live in one shared RAM word per index, so such a write
// reads the word (S_WRRD), merges the new fields and writes it back
// (S_WRWB), and the next beat is taken only after both states. A query beat
// sweeps the segment RAM one entry a cycle while comparing every sprite and
// character against that entry in parallel, so a query walks all SEG_DEPTH
// entries through the single RAM read port. After reset a clearing pass over
// all SEG_DEPTH entries zeroes the segment RAM; no input beat is accepted
// during it, while configuration writes are taken as ever. The result beat
// waits in an output register; the block stays busy until it is taken.
module video_object_collision_detector
  import vocd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [6:0]  in_entry_index,
  input  logic [7:0]  in_left_x,
  input  logic [7:0]  in_right_x,
  input  logic [7:0]  in_top_y,
  input  logic [7:0]  in_bottom_y,
  input  logic        in_shown,
  input  logic [7:0]  in_query_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_collision_bits,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_WRRD, S_WRWB, S_QRUN, S_QLAST, S_OUT}
    state_t;

  state_t state_r;
  logic   dots_en_r;

  logic [7:0] spx0_r [SPRITE_NUM];
  logic [7:0] spx1_r [SPRITE_NUM];
  logic [7:0] spy0_r [SPRITE_NUM];
  logic [7:0] spy1_r [SPRITE_NUM];
  logic [7:0] chx0_r [CHAR_COUNT];
  logic [7:0] chy0_r [CHAR_COUNT];
  logic [7:0] chy1_r [CHAR_COUNT];

  logic [SEG_AW:0]   cnt_r;
  logic [SEG_AW-1:0] addr_r;
  logic [2:0]        act_r;
  logic [7:0]        lx_r, rx_r, ty_r, mask_r;
  logic              sh_r, rd_v_r;
  logic [SPRITE_NUM-1:0] svg_r, shg_r;
  logic              cvg_r, chg_r;
  logic [7:0]        res_r;

  logic              ram_we;
  logic [SEG_AW-1:0] ram_addr;
  seg_word_t         ram_wdata, ram_rdata, merged;
  logic [SEG_W-1:0]  ram_rbits;

  assign ram_rdata = seg_word_t'(ram_rbits);

  vocd_ram #(.WIDTH(SEG_W), .DEPTH(SEG_DEPTH)) u_seg_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rbits)
  );

  logic in_acc;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_collision_bits = res_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {31'd0, dots_en_r} : 32'd0;

  // Merge of the fields a write beat touches into the word read back.
  always_comb begin
    merged = ram_rdata;
    unique case (act_r)
      ACT_VSEG: begin
        merged.v_on = sh_r; merged.v_x0 = lx_r; merged.v_x1 = rx_r; merged.v_y0 = ty_r;
      end
      ACT_HSEG: begin
        merged.h_on = sh_r; merged.h_x0 = lx_r; merged.h_y0 = ty_r;
      end
      ACT_DOT: begin
        merged.d_x0 = lx_r; merged.d_y0 = ty_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = merged;
    ram_addr  = addr_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1; ram_wdata = '0; ram_addr = cnt_r[SEG_AW-1:0];
      end
      S_WRWB:  ram_we = 1'b1;
      S_QRUN:  ram_addr = cnt_r[SEG_AW-1:0];
      default: ;
    endcase
  end

  // Per-entry hits of the word currently read out of the segment RAM.
  logic [SPRITE_NUM-1:0] svg_hit, shg_hit;
  logic cvg_hit, chg_hit;
  always_comb begin
    logic [8:0] vx0, vx1, vy0, vy1, hx0, hx1, hy0, hy1, dx0, dsx1, dcx1, dy0, dy1;
    logic [8:0] ax0, ax1, ay0, ay1;
    vx0 = {1'b0, ram_rdata.v_x0}; vx1 = {1'b0, ram_rdata.v_x1};
    vy0 = {1'b0, ram_rdata.v_y0}; vy1 = vy0 + VSEG_DY;
    hx0 = {1'b0, ram_rdata.h_x0}; hx1 = hx0 + HSEG_DX;
    hy0 = {1'b0, ram_rdata.h_y0}; hy1 = hy0 + HSEG_DY;
    dx0 = {1'b0, ram_rdata.d_x0}; dsx1 = dx0 + DOT_SDX; dcx1 = dx0 + DOT_CDX;
    dy0 = {1'b0, ram_rdata.d_y0}; dy1 = dy0 + HSEG_DY;
    svg_hit = '0; shg_hit = '0; cvg_hit = 1'b0; chg_hit = 1'b0;
    for (int i = 0; i < SPRITE_NUM; i++) begin
      ax0 = {1'b0, spx0_r[i]}; ax1 = {1'b0, spx1_r[i]};
      ay0 = {1'b0, spy0_r[i]}; ay1 = {1'b0, spy1_r[i]};
      svg_hit[i] = ram_rdata.v_on && ends_hit(ax0, ax1, vx0, vx1) &&
                   ends_hit(ay0, ay1, vy0, vy1);
      shg_hit[i] = (ram_rdata.h_on && ends_hit(ax0, ax1, hx0, hx1) &&
                    ends_hit(ay0, ay1, hy0, hy1)) ||
                   (dots_en_r && ends_hit(ax0, ax1, dx0, dsx1) &&
                    ends_hit(ay0, ay1, dy0, dy1));
    end
    for (int k = 0; k < CHAR_COUNT; k++) begin
      ax0 = {1'b0, chx0_r[k]}; ax1 = ax0 + CHAR_DX;
      ay0 = {1'b0, chy0_r[k]}; ay1 = {1'b0, chy1_r[k]};
      if (ram_rdata.v_on && ends_hit(ax0, ax1, vx0, vx1) && ends_hit(ay0, ay1, vy0, vy1))
        cvg_hit = 1'b1;
      if ((ram_rdata.h_on && ends_hit(ax0, ax1, hx0, hx1) && ends_hit(ay0, ay1, hy0, hy1)) ||
          (dots_en_r && ends_hit(ax0, ax1, dx0, dcx1) && ends_hit(ay0, ay1, dy0, dy1)))
        chg_hit = 1'b1;
    end
  end

  // Sprite-to-sprite and sprite-to-character terms from the register tables.
  logic [SPRITE_NUM-1:0] s2s_col, sch;
  always_comb begin
    logic [8:0] cx1;
    s2s_col = '0; sch = '0;
    for (int i = 0; i < SPRITE_NUM; i++) begin
      for (int j = 0; j < SPRITE_NUM; j++) begin
        if (mask_r[i] && i != j && spy0_r[i] != HIDDEN_Y && spy0_r[j] != HIDDEN_Y &&
            ends_hit({1'b0, spx0_r[i]}, {1'b0, spx1_r[i]}, {1'b0, spx0_r[j]},
                     {1'b0, spx1_r[j]}) &&
            ends_hit({1'b0, spy0_r[i]}, {1'b0, spy1_r[i]}, {1'b0, spy0_r[j]},
                     {1'b0, spy1_r[j]}))
          s2s_col[j] = 1'b1;
      end
      for (int k = 0; k < CHAR_COUNT; k++) begin
        cx1 = {1'b0, chx0_r[k]} + CHAR_DX;
        if (spy0_r[i] != HIDDEN_Y && chy0_r[k] != HIDDEN_Y &&
            ends_hit({1'b0, spx0_r[i]}, {1'b0, spx1_r[i]}, {1'b0, chx0_r[k]}, cx1) &&
            ends_hit({1'b0, spy0_r[i]}, {1'b0, spy1_r[i]}, {1'b0, chy0_r[k]},
                     {1'b0, chy1_r[k]}))
          sch[i] = 1'b1;
      end
    end
  end

  // Final collision byte; the last RAM word's hits are folded in here.
  logic [7:0] res_nxt;
  always_comb begin
    logic [SPRITE_NUM-1:0] svg, shg;
    logic cvg, chg;
    svg = svg_r | (rd_v_r ? svg_hit : '0);
    shg = shg_r | (rd_v_r ? shg_hit : '0);
    cvg = cvg_r | (rd_v_r & cvg_hit);
    chg = chg_r | (rd_v_r & chg_hit);
    res_nxt = '0;
    res_nxt[SPRITE_NUM-1:0] = s2s_col | (mask_r[4] ? svg : '0) |
                              (mask_r[5] ? shg : '0) | (mask_r[7] ? sch : '0);
    if ((mask_r[4] && cvg) || (mask_r[5] && chg)) res_nxt[7] = 1'b1;
    if (mask_r[7] && cvg) res_nxt[4] = 1'b1;
    if (mask_r[7] && chg) res_nxt[5] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      dots_en_r <= 1'b0;
      cnt_r     <= '0;
      rd_v_r    <= 1'b0;
      for (int i = 0; i < SPRITE_NUM; i++) begin
        spx0_r[i] <= '0; spx1_r[i] <= '0; spy0_r[i] <= HIDDEN_Y; spy1_r[i] <= '0;
      end
      for (int k = 0; k < CHAR_COUNT; k++) begin
        chx0_r[k] <= '0; chy0_r[k] <= HIDDEN_Y; chy1_r[k] <= '0;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0)
        dots_en_r <= cfg_pwdata[0];
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (SEG_AW+1)'(SEG_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            act_r <= in_action; lx_r <= in_left_x; rx_r <= in_right_x;
            ty_r <= in_top_y; sh_r <= in_shown; mask_r <= in_query_mask;
            addr_r <= in_entry_index[SEG_AW-1:0];
            unique case (in_action)
              ACT_SPRITE: if (in_entry_index < 7'(SPRITE_NUM)) begin
                spx0_r[in_entry_index[1:0]] <= in_left_x;
                spx1_r[in_entry_index[1:0]] <= in_right_x;
                spy0_r[in_entry_index[1:0]] <= in_top_y;
                spy1_r[in_entry_index[1:0]] <= in_bottom_y;
              end
              ACT_CHAR: if (in_entry_index < 7'(CHAR_COUNT)) begin
                chx0_r[in_entry_index[CHAR_AW-1:0]] <= in_left_x;
                chy0_r[in_entry_index[CHAR_AW-1:0]] <= in_top_y;
                chy1_r[in_entry_index[CHAR_AW-1:0]] <= in_bottom_y;
              end
              ACT_VSEG: if ({1'b0, in_entry_index} < 8'(VSEG_COUNT)) state_r <= S_WRRD;
              ACT_HSEG, ACT_DOT:
                if ({1'b0, in_entry_index} < 8'(HSEG_COUNT)) state_r <= S_WRRD;
              ACT_QUERY: begin
                state_r <= S_QRUN; cnt_r <= '0; rd_v_r <= 1'b0;
                svg_r <= '0; shg_r <= '0; cvg_r <= 1'b0; chg_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WRRD: state_r <= S_WRWB;
        S_WRWB: state_r <= S_IDLE;
        S_QRUN: begin
          if (rd_v_r) begin
            svg_r <= svg_r | svg_hit; shg_r <= shg_r | shg_hit;
            cvg_r <= cvg_r | cvg_hit; chg_r <= chg_r | chg_hit;
          end
          rd_v_r <= 1'b1;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == (SEG_AW+1)'(SEG_DEPTH - 1)) state_r <= S_QLAST;
        end
        S_QLAST: begin
          res_r   <= res_nxt;
          rd_v_r  <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // No input beat is taken while a result waits.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input accepted while result pending");
  // A result appears only right after the last sweep cycle.
  assert property (@(posedge clk) disable iff (!rst_n) $rose(out_valid) |-> $past(state_r == S_QLAST))
    else $error("result without finished sweep");
  // The RAM is written back only in the cycle after its read.
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == S_WRWB) |-> $past(state_r == S_WRRD))
    else $error("write-back without read");

endmodule

@@ tb/testbench.sv @@
// Testbench for the video object collision detector: table writes and collision queries.
// Depends on vocd_pkg and video_object_collision_detector; predicts every query result itself.
module testbench;
  import vocd_pkg::*;

  // One input beat as the driver presents it.
  typedef struct {
    action_t    act;
    logic [6:0] idx;
    logic [7:0] lx;
    logic [7:0] rx;
    logic [7:0] ty;
    logic [7:0] by;
    logic       sh;
    logic [7:0] qm;
    logic       pause;  // hold this beat back until every expected result is in
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action = '0;
  logic [6:0]  in_entry_index = '0;
  logic [7:0]  in_left_x = '0, in_right_x = '0, in_top_y = '0, in_bottom_y = '0;
  logic        in_shown = 1'b0;
  logic [7:0]  in_query_mask = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_collision_bits;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0, cfg_paddr = 1'b0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  video_object_collision_detector i_dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the block's tables and its single register.
  logic [7:0] spr_x0 [SPRITE_NUM], spr_x1 [SPRITE_NUM], spr_y0 [SPRITE_NUM], spr_y1 [SPRITE_NUM];
  logic [7:0] chr_x0 [CHAR_COUNT], chr_y0 [CHAR_COUNT], chr_y1 [CHAR_COUNT];
  logic [7:0] vs_x0 [VSEG_COUNT], vs_x1 [VSEG_COUNT], vs_y0 [VSEG_COUNT];
  logic       vs_on [VSEG_COUNT];
  logic [7:0] hs_x0 [HSEG_COUNT], hs_y0 [HSEG_COUNT];
  logic       hs_on [HSEG_COUNT];
  logic [7:0] dot_x0 [HSEG_COUNT], dot_y0 [HSEG_COUNT];
  logic       dots_on;

  beat_t      pending_beats[$];
  logic [7:0] expected_collisions[$];
  int         errors = 0;
  int         queries_checked = 0;
  int         beats_sent = 0;

  // True when one of a's two ends lies inside [lo, hi]; all sums held in 9 bits.
  function automatic bit either_end_in(logic [8:0] a0, logic [8:0] a1,
                                       logic [8:0] lo, logic [8:0] hi);
    return (a0 >= lo && a0 <= hi) || (a1 >= lo && a1 <= hi);
  endfunction

  // A coordinate widened to the 9 bits of the range tests.
  function automatic logic [8:0] w9(logic [7:0] v);
    return {1'b0, v};
  endfunction

  function automatic logic [7:0] predict_collisions(logic [7:0] mask);
    bit s2s [SPRITE_NUM][SPRITE_NUM];
    bit svg [SPRITE_NUM], shg [SPRITE_NUM], sch [SPRITE_NUM];
    bit cvg, chg;
    logic [7:0] r;
    logic [8:0] cx1;
    cvg = 0; chg = 0; r = '0;
    for (int i = 0; i < SPRITE_NUM; i++) begin
      svg[i] = 0; shg[i] = 0; sch[i] = 0;
      for (int j = 0; j < SPRITE_NUM; j++)
        s2s[i][j] = spr_y0[i] != HIDDEN_Y && spr_y0[j] != HIDDEN_Y && i != j &&
                    either_end_in(w9(spr_x0[i]), w9(spr_x1[i]),
                                  w9(spr_x0[j]), w9(spr_x1[j])) &&
                    either_end_in(w9(spr_y0[i]), w9(spr_y1[i]),
                                  w9(spr_y0[j]), w9(spr_y1[j]));
      for (int k = 0; k < VSEG_COUNT; k++)
        if (vs_on[k] &&
            either_end_in(w9(spr_x0[i]), w9(spr_x1[i]), w9(vs_x0[k]), w9(vs_x1[k])) &&
            either_end_in(w9(spr_y0[i]), w9(spr_y1[i]), w9(vs_y0[k]),
                          w9(vs_y0[k]) + 9'd23))
          svg[i] = 1;
      for (int k = 0; k < HSEG_COUNT; k++) begin
        if (hs_on[k] &&
            either_end_in(w9(spr_x0[i]), w9(spr_x1[i]), w9(hs_x0[k]),
                          w9(hs_x0[k]) + 9'd15) &&
            either_end_in(w9(spr_y0[i]), w9(spr_y1[i]), w9(hs_y0[k]),
                          w9(hs_y0[k]) + 9'd2))
          shg[i] = 1;
        if (dots_on &&
            either_end_in(w9(spr_x0[i]), w9(spr_x1[i]), w9(dot_x0[k]),
                          w9(dot_x0[k]) + 9'd3) &&
            either_end_in(w9(spr_y0[i]), w9(spr_y1[i]), w9(dot_y0[k]),
                          w9(dot_y0[k]) + 9'd2))
          shg[i] = 1;
      end
      // Hidden sprites drop out of this test and the sprite-to-sprite test; hidden characters only out of this one.
      if (spr_y0[i] != HIDDEN_Y)
        for (int k = 0; k < CHAR_COUNT; k++)
          if (chr_y0[k] != HIDDEN_Y &&
              either_end_in(w9(spr_x0[i]), w9(spr_x1[i]), w9(chr_x0[k]),
                            w9(chr_x0[k]) + 9'd7) &&
              either_end_in(w9(spr_y0[i]), w9(spr_y1[i]), w9(chr_y0[k]), w9(chr_y1[k])))
            sch[i] = 1;
    end
    for (int i = 0; i < CHAR_COUNT; i++) begin
      cx1 = w9(chr_x0[i]) + 9'd7;
      for (int k = 0; k < VSEG_COUNT; k++)
        if (vs_on[k] && either_end_in(w9(chr_x0[i]), cx1, w9(vs_x0[k]), w9(vs_x1[k])) &&
            either_end_in(w9(chr_y0[i]), w9(chr_y1[i]), w9(vs_y0[k]),
                          w9(vs_y0[k]) + 9'd23))
          cvg = 1;
      for (int k = 0; k < HSEG_COUNT; k++) begin
        if (hs_on[k] &&
            either_end_in(w9(chr_x0[i]), cx1, w9(hs_x0[k]), w9(hs_x0[k]) + 9'd15) &&
            either_end_in(w9(chr_y0[i]), w9(chr_y1[i]), w9(hs_y0[k]),
                          w9(hs_y0[k]) + 9'd2))
          chg = 1;
        if (dots_on &&
            either_end_in(w9(chr_x0[i]), cx1, w9(dot_x0[k]), w9(dot_x0[k]) + 9'd15) &&
            either_end_in(w9(chr_y0[i]), w9(chr_y1[i]), w9(dot_y0[k]),
                          w9(dot_y0[k]) + 9'd2))
          chg = 1;
      end
    end
    for (int i = 0; i < SPRITE_NUM; i++) begin
      if (mask[i])
        for (int j = 0; j < SPRITE_NUM; j++)
          if (s2s[i][j]) r[j] = 1'b1;
      if ((mask[4] && svg[i]) || (mask[5] && shg[i]) || (mask[7] && sch[i])) r[i] = 1'b1;
    end
    if ((mask[4] && cvg) || (mask[5] && chg)) r[7] = 1'b1;
    if (mask[7] && cvg) r[4] = 1'b1;
    if (mask[7] && chg) r[5] = 1'b1;
    return r;
  endfunction

  // Applies one accepted beat to the shadow tables; a query queues its answer.
  function automatic void apply_beat(beat_t b);
    case (b.act)
      ACT_SPRITE: if (b.idx < SPRITE_NUM) begin
        spr_x0[b.idx] = b.lx; spr_x1[b.idx] = b.rx;
        spr_y0[b.idx] = b.ty; spr_y1[b.idx] = b.by;
      end
      ACT_CHAR: if (b.idx < CHAR_COUNT) begin
        chr_x0[b.idx] = b.lx; chr_y0[b.idx] = b.ty; chr_y1[b.idx] = b.by;
      end
      ACT_VSEG: if (b.idx < VSEG_COUNT) begin
        vs_x0[b.idx] = b.lx; vs_x1[b.idx] = b.rx; vs_y0[b.idx] = b.ty; vs_on[b.idx] = b.sh;
      end
      ACT_HSEG: if (b.idx < HSEG_COUNT) begin
        hs_x0[b.idx] = b.lx; hs_y0[b.idx] = b.ty; hs_on[b.idx] = b.sh;
      end
      ACT_DOT: if (b.idx < HSEG_COUNT) begin
        dot_x0[b.idx] = b.lx; dot_y0[b.idx] = b.ty;
      end
      ACT_QUERY: expected_collisions.push_back(predict_collisions(b.qm));
      default: ;  // unused actions leave every table alone
    endcase
  endfunction

  function automatic beat_t make_beat(logic [2:0] act, logic [6:0] idx, logic [7:0] lx,
                                      logic [7:0] rx, logic [7:0] ty, logic [7:0] by,
                                      logic sh, logic [7:0] qm);
    beat_t b;
    b.act = action_t'(act); b.idx = idx; b.lx = lx; b.rx = rx;
    b.ty = ty; b.by = by; b.sh = sh; b.qm = qm; b.pause = 1'b0;
    return b;
  endfunction

  // Random beat. Coordinates cluster in a small window most of the time so that
  // boxes actually overlap; sprite and character indexes mostly land in range with some past the end.
  function automatic beat_t random_beat();
    logic [2:0] act;
    logic [7:0] base;
    logic [6:0] idx;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 14) act = ACT_SPRITE;
    else if (pick < 26) act = ACT_CHAR;
    else if (pick < 38) act = ACT_VSEG;
    else if (pick < 50) act = ACT_HSEG;
    else if (pick < 60) act = ACT_DOT;
    else if (pick < 97) act = ACT_QUERY;
    else act = 3'($urandom_range(6, 7));
    base = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(40, 90));
    case (act)
      ACT_SPRITE: idx = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 3));
      ACT_CHAR:   idx = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 15));
      default:    idx = 7'($urandom);
    endcase
    return make_beat(act, idx, base, base + 8'($urandom_range(0, 30)),
                     ($urandom_range(0, 7) == 0) ? HIDDEN_Y : base + 8'($urandom_range(0, 20)),
                     base + 8'($urandom_range(0, 40)), 1'($urandom), 8'($urandom));
  endfunction

  // APB write of the dots_enabled register, made while the block is idle or clearing after reset.
  task automatic write_dots_enabled(logic value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= 1'b0;
    cfg_pwdata <= {31'b0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    dots_on = value;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // Waits for the driver to drain and every answer to arrive, plus slack for
  // a write that may still be finishing inside the block.
  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_collisions.size() != 0)
      @(posedge clk);
    repeat (SEG_DEPTH + 10) @(posedge clk);
  endtask

  // Acceptance is recorded at the rising edge and applied to the shadow state
  // there, so the driver only reads a flag that has already settled.
  bit in_ready_seen = 1'b0;

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_seen) begin
        // The previous beat was taken at the last rising edge.
      end
      if (!in_valid || in_ready_seen) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].pause && expected_collisions.size() != 0)) begin
          in_valid <= 1'b1;
          in_action <= pending_beats[0].act;
          in_entry_index <= pending_beats[0].idx;
          in_left_x <= pending_beats[0].lx;
          in_right_x <= pending_beats[0].rx;
          in_top_y <= pending_beats[0].ty;
          in_bottom_y <= pending_beats[0].by;
          in_shown <= pending_beats[0].sh;
          in_query_mask <= pending_beats[0].qm;
          void'(pending_beats.pop_front());
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    in_ready_seen <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      apply_beat(beat_t'{action_t'(in_action), in_entry_index, in_left_x, in_right_x,
                         in_top_y, in_bottom_y, in_shown, in_query_mask, 1'b0});
      beats_sent <= beats_sent + 1;
    end
  end

  // Receiver stall pattern: long ready stretches, then stalls of varied length.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 97;
    if (stall_phase < 40) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0) && (stall_phase % 13 != 0);
  end

  // Monitor: each result beat against the oldest expected answer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_collisions.size() == 0) begin
        $display("%0t: unexpected result beat, actual %02h", $time, out_collision_bits);
        errors <= errors + 1;
      end else begin
        if (out_collision_bits !== expected_collisions[0]) begin
          $display("%0t: collision_bits mismatch, expected %02h, actual %02h",
                   $time, expected_collisions[0], out_collision_bits);
          errors <= errors + 1;
        end
        void'(expected_collisions.pop_front());
        queries_checked <= queries_checked + 1;
      end
    end
  end

  initial begin
    beat_t b;
    for (int i = 0; i < SPRITE_NUM; i++) begin
      spr_x0[i] = 0; spr_x1[i] = 0; spr_y0[i] = HIDDEN_Y; spr_y1[i] = 0;
    end
    for (int i = 0; i < CHAR_COUNT; i++) begin
      chr_x0[i] = 0; chr_y0[i] = HIDDEN_Y; chr_y1[i] = 0;
    end
    for (int i = 0; i < SEG_DEPTH; i++) begin
      vs_x0[i] = 0; vs_x1[i] = 0; vs_y0[i] = 0; vs_on[i] = 0;
      hs_x0[i] = 0; hs_y0[i] = 0; hs_on[i] = 0; dot_x0[i] = 0; dot_y0[i] = 0;
    end
    dots_on = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: reset-state query, then boxes at the coordinate extremes,
    // hidden objects against grids, out-of-range indexes, unused actions.
    write_dots_enabled(1'b1);
    pending_beats.push_back(make_beat(ACT_QUERY, 0, 0, 0, 0, 0, 0, 8'hFF));
    pending_beats.push_back(make_beat(ACT_SPRITE, 0, 10, 20, 10, 20, 0, 0));
    pending_beats.push_back(make_beat(ACT_SPRITE, 1, 15, 30, 15, 30, 0, 0));
    pending_beats.push_back(make_beat(ACT_SPRITE, 2, 255, 255, 255, 255, 0, 0));
    pending_beats.push_back(make_beat(ACT_SPRITE, 3, 12, 18, HIDDEN_Y, 255, 0, 0));
    pending_beats.push_back(make_beat(ACT_CHAR, 15, 250, 0, 240, 255, 0, 0));
    pending_beats.push_back(make_beat(ACT_CHAR, 0, 14, 0, 12, 16, 0, 0));
    pending_beats.push_back(make_beat(ACT_CHAR, 1, 8, 0, HIDDEN_Y, 255, 0, 0));
    pending_beats.push_back(make_beat(ACT_VSEG, 127, 240, 255, 240, 0, 1, 0));
    pending_beats.push_back(make_beat(ACT_VSEG, 0, 5, 16, 0, 0, 1, 0));
    pending_beats.push_back(make_beat(ACT_HSEG, 127, 250, 0, 254, 0, 1, 0));
    pending_beats.push_back(make_beat(ACT_HSEG, 3, 0, 0, 247, 0, 1, 0));
    pending_beats.push_back(make_beat(ACT_DOT, 5, 253, 0, 253, 0, 0, 0));
    pending_beats.push_back(make_beat(ACT_DOT, 6, 9, 0, 9, 0, 0, 0));
    pending_beats.push_back(make_beat(ACT_SPRITE, 100, 1, 2, 3, 4, 0, 0));
    pending_beats.push_back(make_beat(ACT_CHAR, 16, 1, 2, 3, 4, 0, 0));
    pending_beats.push_back(make_beat(3'd6, 0, 0, 0, 0, 0, 0, 8'hFF));
    pending_beats.push_back(make_beat(3'd7, 127, 255, 255, 255, 255, 1, 8'hFF));
    for (int m = 0; m < 8; m++)
      pending_beats.push_back(make_beat(ACT_QUERY, 0, 0, 0, 0, 0, 0, 8'(1 << m)));
    pending_beats.push_back(make_beat(ACT_QUERY, 0, 0, 0, 0, 0, 0, 8'hFF));
    wait_idle();
    write_dots_enabled(1'b0);
    pending_beats.push_back(make_beat(ACT_QUERY, 0, 0, 0, 0, 0, 0, 8'hFF));

    // Random part in four phases; the register is rewritten between them and is on only in the third.
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 400; n++) begin
        b = random_beat();
        // Now and then hold a beat until all answers are in.
        if (n % 150 == 75) b.pause = 1'b1;
        pending_beats.push_back(b);
      end
      wait_idle();
      write_dots_enabled(phase[0]);
    end
    wait_idle();
    $display("Sent %0d beats, checked %0d collision queries across both dot settings.",
             beats_sent, queries_checked);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Slowest run: 1600 random beats, over a third of them queries that sweep the whole segment RAM,
  // with receiver stalls and sender gaps; 20 million time units is many times that.
  initial begin
    #20000000;
    $display("Timeout with %0d answers still expected.", expected_collisions.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
